### src/fdss_pkg.sv
// Shared types, constants and digit tables for the seven-segment scan driver.
package fdss_pkg;

  localparam int DIGITS = 4;
  localparam int PIN_SHIFT = 13;
  localparam int PIN_W = 22;

  typedef logic [3:0] bcd_t;
  typedef logic [7:0] seg_pat_t;
  typedef seg_pat_t [DIGITS-1:0] digit_pats_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // register indexes on the config channel
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_SOURCE = 2'd1;

  // source select codes; the unused code 3 also reads as temperature
  localparam logic [1:0] SRC_TEMP    = 2'd0;
  localparam logic [1:0] SRC_SENSOR2 = 2'd1;
  localparam logic [1:0] SRC_TIME    = 2'd2;

  localparam logic [13:0] MAG_MAX  = 14'd9999;
  localparam logic [6:0]  HOLD_LIT = 7'd103;

  // reciprocal multipliers: x/1000 = (x*8389)>>23, x/100 = (x*41)>>12, x/10 = (x*103)>>10
  localparam logic [13:0] RECIP_1000 = 14'd8389;
  localparam logic [5:0]  RECIP_100  = 6'd41;
  localparam logic [6:0]  RECIP_10   = 7'd103;

  function automatic seg_pat_t seg_of(input bcd_t d);
    seg_pat_t p;
    unique case (d)
      4'd0: p = 8'hfc;
      4'd1: p = 8'h60;
      4'd2: p = 8'hda;
      4'd3: p = 8'hf2;
      4'd4: p = 8'h66;
      4'd5: p = 8'hb6;
      4'd6: p = 8'hbe;
      4'd7: p = 8'he0;
      4'd8: p = 8'hfe;
      4'd9: p = 8'hf6;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [13:0] times_1000(input bcd_t q);
    logic [13:0] v;
    unique case (q)
      4'd0: v = 14'd0;
      4'd1: v = 14'd1000;
      4'd2: v = 14'd2000;
      4'd3: v = 14'd3000;
      4'd4: v = 14'd4000;
      4'd5: v = 14'd5000;
      4'd6: v = 14'd6000;
      4'd7: v = 14'd7000;
      4'd8: v = 14'd8000;
      4'd9: v = 14'd9000;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] times_100(input bcd_t q);
    logic [9:0] v;
    unique case (q)
      4'd0: v = 10'd0;
      4'd1: v = 10'd100;
      4'd2: v = 10'd200;
      4'd3: v = 10'd300;
      4'd4: v = 10'd400;
      4'd5: v = 10'd500;
      4'd6: v = 10'd600;
      4'd7: v = 10'd700;
      4'd8: v = 10'd800;
      4'd9: v = 10'd900;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] times_10(input bcd_t q);
    logic [6:0] v;
    unique case (q)
      4'd0: v = 7'd0;
      4'd1: v = 7'd10;
      4'd2: v = 7'd20;
      4'd3: v = 7'd30;
      4'd4: v = 7'd40;
      4'd5: v = 7'd50;
      4'd6: v = 7'd60;
      4'd7: v = 7'd70;
      4'd8: v = 7'd80;
      4'd9: v = 7'd90;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

### src/fdss_front.sv
// Front end: accepts refresh items, splits them into digits, maps to segment patterns.
module fdss_front import fdss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              display_enable,
  input  logic [1:0]        source_select,
  input  logic signed [15:0] temperature,
  input  logic [5:0]        minutes,
  input  logic [5:0]        seconds,
  input  q_status_t         q_status,
  output logic              push,
  output digit_pats_t       push_pats
);

  typedef struct packed {
    logic        time_mode;
    logic        neg;
    logic [13:0] mag;
    logic [5:0]  mins;
    logic [5:0]  secs;
  } s1_t;

  typedef struct packed {
    logic                   time_mode;
    logic                   neg;
    bcd_t                   thou;
    logic [9:0]             rem;
    bcd_t [DIGITS-1:0]      tdig;
  } s2_t;

  typedef struct packed {
    logic                   time_mode;
    logic                   neg;
    bcd_t                   thou;
    bcd_t                   hund;
    logic [6:0]             rem;
    bcd_t [DIGITS-1:0]      tdig;
  } s3_t;

  logic adv, acc, keep;
  logic v1, v2, v3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;

  logic        neg_in;
  logic [16:0] abs_in;

  logic [27:0] p3;
  bcd_t        q3;
  logic [12:0] pm, ps;
  bcd_t        mt, mo, st, so;
  logic [15:0] p2;
  bcd_t        q2;
  logic [13:0] p1;
  bcd_t        q1, q0;
  bcd_t [DIGITS-1:0] dig;

  // whole front advances together; holds only when the last stage cannot push
  assign adv  = !(v3 && q_status.full);
  assign busy = !adv;
  assign acc  = start && adv;
  assign keep = display_enable && (source_select != SRC_SENSOR2);

  // stage 1: classify and take the saturated magnitude
  always_comb begin
    neg_in = temperature[15];
    abs_in = neg_in ? 17'(17'h10000 - {1'b0, temperature}) : {1'b0, temperature};
    s1_next.time_mode = (source_select == SRC_TIME);
    s1_next.neg       = neg_in;
    s1_next.mag       = (abs_in > 17'(MAG_MAX)) ? MAG_MAX : abs_in[13:0];
    s1_next.mins      = minutes;
    s1_next.secs      = seconds;
  end

  // stage 2: thousands digit, and both time digit pairs
  always_comb begin
    p3 = 28'(s1.mag) * 28'(RECIP_1000);
    q3 = p3[26:23];
    pm = 13'(s1.mins) * 13'(RECIP_10);
    ps = 13'(s1.secs) * 13'(RECIP_10);
    mt = {1'b0, pm[12:10]};
    st = {1'b0, ps[12:10]};
    mo = 4'(7'(s1.mins) - times_10(mt));
    so = 4'(7'(s1.secs) - times_10(st));
    s2_next.time_mode = s1.time_mode;
    s2_next.neg       = s1.neg;
    s2_next.thou      = q3;
    s2_next.rem       = 10'(s1.mag - times_1000(q3));
    s2_next.tdig      = {mt, mo, st, so};
  end

  // stage 3: hundreds digit
  always_comb begin
    p2 = 16'(s2.rem) * 16'(RECIP_100);
    q2 = p2[15:12];
    s3_next.time_mode = s2.time_mode;
    s3_next.neg       = s2.neg;
    s3_next.thou      = s2.thou;
    s3_next.hund      = q2;
    s3_next.rem       = 7'(s2.rem - times_100(q2));
    s3_next.tdig      = s2.tdig;
  end

  // last stage: tens and ones, pick source, map to segments
  always_comb begin
    p1 = 14'(s3.rem) * 14'(RECIP_10);
    q1 = p1[13:10];
    q0 = 4'(s3.rem - times_10(q1));
    if (s3.time_mode) begin
      dig = s3.tdig;
    end else begin
      dig = {(s3.neg ? 4'd1 : s3.thou), s3.hund, q1, q0};
    end
    for (int i = 0; i < DIGITS; i++) begin
      push_pats[i] = seg_of(dig[i]);
    end
  end

  assign push = v3 && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= acc && keep;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

endmodule

### src/fdss_queue.sv
// Two-entry queue of digit patterns between the front end and the scanner.
module fdss_queue import fdss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  digit_pats_t push_pats,
  input  logic        pop,
  output digit_pats_t pop_pats,
  output q_status_t   status
);

  digit_pats_t entries [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count, count_next;

  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);
  assign pop_pats     = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = 2'(count + 2'd1);
    end else if (pop && !push) begin
      count_next = 2'(count - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pats;
    end
  end

endmodule

### src/fdss_back.sv
// Scanner: plays one queued item as eight pin states, lit then blank per digit.
module fdss_back import fdss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_status_t         q_status,
  input  digit_pats_t       pop_pats,
  output logic              pop,
  output logic              strobe,
  output logic [PIN_W-1:0]  segment_pins,
  output logic [3:0]        digit_select,
  output logic [6:0]        hold_us,
  output logic              last_of_scan
);

  logic        active;
  logic [2:0]  step;
  digit_pats_t pats;
  logic        lit;
  logic [1:0]  slot;
  seg_pat_t    pat;

  // next item starts right after the last blank of the current one
  assign pop = !q_status.empty && (!active || (step == 3'd7));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= 3'd0;
    end else if (pop) begin
      active <= 1'b1;
      step   <= 3'd0;
    end else if (active) begin
      if (step == 3'd7) begin
        active <= 1'b0;
      end
      step <= 3'(step + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pats <= pop_pats;
    end
  end

  // step/2 counts select lines from bit 0; that line lights digit 3 - step/2
  always_comb begin
    lit          = !step[0];
    slot         = step[2:1];
    pat          = pats[~slot];
    strobe       = active;
    segment_pins = lit ? {pat[7], pat, {PIN_SHIFT{1'b0}}} : '0;
    digit_select = lit ? ~(4'b0001 << slot) : 4'hF;
    hold_us      = lit ? HOLD_LIT : 7'd0;
    last_of_scan = active && (step == 3'd7);
  end

endmodule

### src/four_digit_seven_segment_scan.sv
// Top level of the four-digit multiplexed seven-segment scan driver.
//
// A refresh item (temperature, minutes, seconds) is taken at a clock edge with
// start high and busy low. Depending on the config registers it becomes four
// decimal digits (temperature magnitude, saturated at 9999, or minutes and
// seconds), or is dropped when the display is disabled or the second-sensor
// source is selected. Each kept item gives eight results, highest digit first:
// a lit pin state with one select line low, then a blank one; the last blank
// carries last_of_scan. A result shows for exactly one cycle with strobe high.
// An accepted item passes pipeline registers s1, s2, s3, then the queue, then
// the scanner's pattern register; its eight results follow in consecutive
// cycles. The single result port limits the sustained rate. A three-stage
// digit pipeline and a two-entry queue take new items while the scanner runs;
// busy rises only when the last pipeline stage holds an item and the queue is
// full. Config writes (cfg_valid, always ready) should be made only while idle;
// the block itself does not enforce this. Reset: display enabled, temperature
// source, pipeline and queue empty. The receiver cannot stall; no result waits.
module four_digit_seven_segment_scan import fdss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] temperature,
  input  logic [5:0]         minutes,
  input  logic [5:0]         seconds,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data,
  output logic               strobe,
  output logic [PIN_W-1:0]   segment_pins,
  output logic [3:0]         digit_select,
  output logic [6:0]         hold_us,
  output logic               last_of_scan
);

  logic        display_enable;
  logic [1:0]  source_select;
  logic        push, pop;
  digit_pats_t push_pats, pop_pats;
  q_status_t   q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable <= 1'b1;
      source_select  <= SRC_TEMP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE: display_enable <= cfg_data[0];
        REG_SOURCE: source_select  <= cfg_data;
        default: ;
      endcase
    end
  end

  fdss_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .display_enable (display_enable),
    .source_select  (source_select),
    .temperature    (temperature),
    .minutes        (minutes),
    .seconds        (seconds),
    .q_status       (q_status),
    .push           (push),
    .push_pats      (push_pats)
  );

  fdss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_pats (push_pats),
    .pop       (pop),
    .pop_pats  (pop_pats),
    .status    (q_status)
  );

  fdss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .pop_pats     (pop_pats),
    .pop          (pop),
    .strobe       (strobe),
    .segment_pins (segment_pins),
    .digit_select (digit_select),
    .hold_us      (hold_us),
    .last_of_scan (last_of_scan)
  );

endmodule
